// ===== hw/rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants of the interpolating sample player: beat
// payloads, request codes, register indexes and their reset values.
// ----------------------------------------------------------------------------
package isp_pkg;

  // request codes
  localparam logic [2:0] REQ_RENDER = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_PLAY   = 3'd2;
  localparam logic [2:0] REQ_PAUSE  = 3'd3;
  localparam logic [2:0] REQ_STOP   = 3'd4;
  localparam logic [2:0] REQ_SEEK   = 3'd5;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  // register widths
  localparam int STEP_W = 20;
  localparam int VOL_W  = 16;
  localparam int FCNT_W = 17;
  localparam int CCNT_W = 2;

  // reset values, unity gain is 1.0 in Q1.15
  localparam logic [STEP_W-1:0] STEP_RESET   = 20'd65536;
  localparam logic [VOL_W-1:0]  VOLUME_UNITY = 16'd32768;
  localparam logic [CCNT_W-1:0] CCNT_RESET   = 2'd1;

  // width of the frame number in a result
  localparam int POS_FRAME_W = 17;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic [15:0]        load_index;
    logic signed [15:0] load_left;
    logic signed [15:0] load_right;
    logic [15:0]        seek_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]     out_left;
    logic signed [15:0]     out_right;
    logic                   is_playing;
    logic [POS_FRAME_W-1:0] position_frame;
    logic                   finished;
    logic                   status;
  } out_item_t;

  // stage enables of a lane
  typedef struct packed {
    logic mul_en;
    logic vol_en;
  } lane_ctl_t;

  // item context handed to the merge stage
  typedef struct packed {
    logic                   render;
    logic                   active;
    logic                   is_playing;
    logic [POS_FRAME_W-1:0] position_frame;
    logic                   finished;
    logic                   status;
  } result_ctx_t;

endpackage

// ===== hw/rtl/isp_store.sv =====
// ----------------------------------------------------------------------------
// isp_store
// Stereo sample memory: one write port for loads, two registered read ports
// that fetch a frame and its successor together.
// ----------------------------------------------------------------------------
module isp_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports, data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/isp_lane.sv =====
// ----------------------------------------------------------------------------
// isp_lane
// One output channel: picks its stored channel from two adjacent frames,
// blends them by the phase fraction, scales by volume, rounds, mixes and saturates.
// ----------------------------------------------------------------------------
module isp_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  isp_pkg::lane_ctl_t    ctl,
  input  logic [31:0]           word_a,
  input  logic [31:0]           word_b,
  input  logic                  sel_high,
  input  logic [FRAC_BITS-1:0]  frac,
  input  logic [15:0]           volume,
  input  logic signed [15:0]    mix,
  output logic signed [15:0]    sample
);

  localparam int ACC_W  = FRAC_BITS + 17;
  localparam int PROD_W = ACC_W + 17;
  localparam int SH     = FRAC_BITS + 15;
  localparam int V_W    = PROD_W - SH;
  localparam int SUM_W  = V_W + 1;
  localparam logic [PROD_W-1:0] RND =
    {{(PROD_W - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] POS_LIM = 32767;
  localparam logic signed [SUM_W-1:0] NEG_LIM = -32768;

  logic signed [15:0]       a_s;
  logic signed [15:0]       b_s;
  logic [FRAC_BITS:0]       w0_u;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_rnd;
  logic [V_W-1:0]           voice;
  logic signed [SUM_W-1:0]  total;

  // stored channel select
  assign a_s = sel_high ? word_a[31:16] : word_a[15:0];
  assign b_s = sel_high ? word_b[31:16] : word_b[15:0];

  // weight of the earlier frame
  assign w0_u = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};

  // linear blend
  assign acc_next = ACC_W'(a_s) * ACC_W'($signed({1'b0, w0_u}))
                  + ACC_W'(b_s) * ACC_W'($signed({2'b00, frac}));

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      acc <= acc_next;
    end
  end

  // volume scaling
  always_ff @(posedge clk) begin
    if (ctl.vol_en) begin
      prod <= PROD_W'(acc) * PROD_W'($signed({1'b0, volume}));
    end
  end

  // round half up, add onto the mix
  assign prod_rnd = prod + RND;
  assign voice    = prod_rnd[PROD_W-1:SH];
  assign total    = {{(SUM_W - 16){mix[15]}}, mix} + {voice[V_W-1], voice};

  // saturate to 16 bits
  always_comb begin
    if (total > POS_LIM) begin
      sample = POS_LIM[15:0];
    end else if (total < NEG_LIM) begin
      sample = NEG_LIM[15:0];
    end else begin
      sample = total[15:0];
    end
  end

endmodule

// ===== hw/rtl/isp_merge.sv =====
// ----------------------------------------------------------------------------
// isp_merge
// Combines both lanes with the item's flags into the result register and
// holds it until the output beat is taken.
// ----------------------------------------------------------------------------
module isp_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  isp_pkg::result_ctx_t  ctx,
  input  logic signed [15:0]    lane_left,
  input  logic signed [15:0]    lane_right,
  input  logic signed [15:0]    mix_left,
  input  logic signed [15:0]    mix_right,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output isp_pkg::out_item_t    out_data
);

  isp_pkg::out_item_t result;

  // pick lane, pass-through or zero
  always_comb begin
    result.is_playing     = ctx.is_playing;
    result.position_frame = ctx.position_frame;
    result.finished       = ctx.finished;
    result.status         = ctx.status;
    if (!ctx.render) begin
      result.out_left  = '0;
      result.out_right = '0;
    end else if (ctx.active) begin
      result.out_left  = lane_left;
      result.out_right = lane_right;
    end else begin
      result.out_left  = mix_left;
      result.out_right = mix_right;
    end
  end

  assign can_load = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/interpolating_sample_player_unit.sv =====
// ----------------------------------------------------------------------------
// interpolating_sample_player_unit: stereo sample playback with linear interp.
// A new input beat is taken only in idle, once the read / blend multiply /
// volume multiply / output sequence is through; output waits on a held result.
// Sync reset clears position, playing flag, registers; store is not cleared.
// ----------------------------------------------------------------------------
module interpolating_sample_player_unit #(
  parameter int MAX_FRAMES = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  isp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output isp_pkg::out_item_t                out_data,
  input  logic                              cfg_write,
  input  logic [isp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FR_W   = $clog2(MAX_FRAMES + 1);
  localparam int POS_W  = ADDR_W + FRAC_BITS;
  localparam int CNT_W  = (FR_W > isp_pkg::FCNT_W) ? FR_W : isp_pkg::FCNT_W;
  localparam int SW     = (FR_W > 16) ? FR_W : 16;
  localparam int END_W  = FR_W + FRAC_BITS;
  localparam int D_W    = ((END_W > isp_pkg::STEP_W) ? END_W : isp_pkg::STEP_W) + 1;
  localparam int PF_W   = (ADDR_W > isp_pkg::POS_FRAME_W) ? ADDR_W : isp_pkg::POS_FRAME_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_VOL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [isp_pkg::STEP_W-1:0] step_ratio;
  logic [isp_pkg::VOL_W-1:0]  volume;
  logic                       mute;
  logic [isp_pkg::FCNT_W-1:0] frame_count;
  logic [isp_pkg::CCNT_W-1:0] channel_count;

  // playback state
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             playing;
  logic             playing_next;
  logic             fin_next;
  logic             status_next;

  // item context
  logic signed [15:0]      mix_left;
  logic signed [15:0]      mix_right;
  logic [FRAC_BITS-1:0]    frac;
  logic                    sel_right;
  isp_pkg::result_ctx_t    ctx;

  logic                    accept;
  logic [CNT_W-1:0]        fc_ext;
  logic [FR_W-1:0]         frames;
  logic [ADDR_W-1:0]       last_a;
  logic                    has_buf;
  logic                    active;
  logic [POS_W-1:0]        last_pos;
  logic [POS_W-1:0]        cpos;
  logic [ADDR_W-1:0]       idx;
  logic                    has_next;
  logic [ADDR_W-1:0]       raddr_b;
  logic [D_W-1:0]          end_v;
  logic [D_W-1:0]          diff;
  logic [D_W-1:0]          step_sum;
  logic                    ends;
  logic                    load_ok;
  logic [SW-1:0]           seek_ext;
  logic [SW-1:0]           last_s;
  logic [ADDR_W-1:0]       seek_a;
  logic [PF_W-1:0]         pf_ext;
  logic [31:0]             rdata_a;
  logic [31:0]             rdata_b;
  logic signed [15:0]      lane_left;
  logic signed [15:0]      lane_right;
  isp_pkg::lane_ctl_t      lane_ctl;
  logic                    can_load;
  logic                    out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= isp_pkg::STEP_RESET;
      volume        <= isp_pkg::VOLUME_UNITY;
      mute          <= 1'b0;
      frame_count   <= '0;
      channel_count <= isp_pkg::CCNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        isp_pkg::REG_STEP_RATIO:    step_ratio    <= cfg_data[isp_pkg::STEP_W-1:0];
        isp_pkg::REG_VOLUME:        volume        <= cfg_data[isp_pkg::VOL_W-1:0];
        isp_pkg::REG_MUTE:          mute          <= cfg_data[0];
        isp_pkg::REG_FRAME_COUNT:   frame_count   <= cfg_data[isp_pkg::FCNT_W-1:0];
        isp_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[isp_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // frames in use and buffer presence
  assign fc_ext  = CNT_W'(frame_count);
  assign frames  = (fc_ext > CNT_W'(MAX_FRAMES)) ? FR_W'(MAX_FRAMES) : FR_W'(fc_ext);
  assign last_a  = ADDR_W'(frames - FR_W'(1));
  assign has_buf = (frames != '0) && (channel_count != '0);
  assign active  = playing && !mute && has_buf;

  // read position clamped to the last frame
  assign last_pos = {last_a, {FRAC_BITS{1'b0}}};
  assign cpos     = (pos >= last_pos) ? last_pos : pos;
  assign idx      = cpos[POS_W-1:FRAC_BITS];
  assign has_next = (idx < last_a);
  assign raddr_b  = has_next ? idx + ADDR_W'(1) : idx;

  // end of buffer check and advance
  assign end_v    = D_W'(frames) << FRAC_BITS;
  assign diff     = end_v - D_W'(pos);
  assign ends     = diff[D_W-1] || (diff <= D_W'(step_ratio));
  assign step_sum = D_W'(pos) + D_W'(step_ratio);

  // load range and seek clamp
  assign load_ok  = SW'(in_data.load_index) < SW'(MAX_FRAMES);
  assign seek_ext = SW'(in_data.seek_index);
  assign last_s   = SW'(last_a);
  assign seek_a   = ADDR_W'((seek_ext > last_s) ? last_s : seek_ext);

  // request decode
  always_comb begin
    pos_next     = pos;
    playing_next = playing;
    fin_next     = 1'b0;
    status_next  = 1'b0;
    case (in_data.req_type)
      isp_pkg::REQ_RENDER: begin
        if (active) begin
          if (ends) begin
            playing_next = 1'b0;
            pos_next     = '0;
            fin_next     = 1'b1;
          end else begin
            pos_next = POS_W'(step_sum);
          end
        end
      end
      isp_pkg::REQ_LOAD: begin
        if (load_ok) begin
          pos_next = '0;
        end
      end
      isp_pkg::REQ_PLAY: begin
        if (has_buf) begin
          playing_next = 1'b1;
        end else begin
          status_next = 1'b1;
        end
      end
      isp_pkg::REQ_PAUSE: begin
        playing_next = 1'b0;
      end
      isp_pkg::REQ_STOP: begin
        playing_next = 1'b0;
        pos_next     = '0;
      end
      isp_pkg::REQ_SEEK: begin
        if (frames != '0) begin
          pos_next = {seek_a, {FRAC_BITS{1'b0}}};
        end else begin
          status_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pf_ext = PF_W'(pos_next[POS_W-1:FRAC_BITS]);

  // playback state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      playing <= 1'b0;
    end else if (accept) begin
      pos     <= pos_next;
      playing <= playing_next;
    end
  end

  // capture item context
  always_ff @(posedge clk) begin
    if (accept) begin
      mix_left           <= in_data.mix_left;
      mix_right          <= in_data.mix_right;
      frac               <= cpos[FRAC_BITS-1:0];
      sel_right          <= channel_count[1];
      ctx.render         <= (in_data.req_type == isp_pkg::REQ_RENDER);
      ctx.active         <= active;
      ctx.is_playing     <= playing_next;
      ctx.position_frame <= pf_ext[isp_pkg::POS_FRAME_W-1:0];
      ctx.finished       <= fin_next;
      ctx.status         <= status_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_MUL;
      S_MUL:   state_next = S_VOL;
      S_VOL:   state_next = S_OUT;
      S_OUT:   if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign lane_ctl.mul_en = (state == S_MUL);
  assign lane_ctl.vol_en = (state == S_VOL);
  assign out_load        = (state == S_OUT) && can_load;

  // sample memory
  isp_store #(
    .DEPTH  (MAX_FRAMES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (accept && (in_data.req_type == isp_pkg::REQ_LOAD) && load_ok),
    .waddr   (ADDR_W'(in_data.load_index)),
    .wdata   ({in_data.load_right, in_data.load_left}),
    .re      (accept),
    .raddr_a (idx),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // left lane reads stored channel 0
  isp_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_left (
    .clk      (clk),
    .ctl      (lane_ctl),
    .word_a   (rdata_a),
    .word_b   (rdata_b),
    .sel_high (1'b0),
    .frac     (frac),
    .volume   (volume),
    .mix      (mix_left),
    .sample   (lane_left)
  );

  // right lane reads stored channel 1 when the channel count is two or more
  isp_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_right (
    .clk      (clk),
    .ctl      (lane_ctl),
    .word_a   (rdata_a),
    .word_b   (rdata_b),
    .sel_high (sel_right),
    .frac     (frac),
    .volume   (volume),
    .mix      (mix_right),
    .sample   (lane_right)
  );

  // result merge and output register
  isp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .ctx        (ctx),
    .lane_left  (lane_left),
    .lane_right (lane_right),
    .mix_left   (mix_left),
    .mix_right  (mix_right),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== tb/sv/isp_player_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_player_checker
// Watches the request, result and register ports of the sample player. Keeps
// its own copy of the store, position, playing flag and registers, works out
// the result of every request beat and compares each result beat with the
// oldest one still owed. Hands the failure, owed, voiced and finished counts upward.
// ----------------------------------------------------------------------------
module isp_player_checker
  import isp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    n_voiced,
  output int                    n_finished
);

  localparam logic [16:0] FRAMES_MAX = 17'd65536;
  localparam longint      ROUND_HALF = 64'sd1 << 30;

  // player state as the block should hold it
  bit   [31:0]       sample_mem [0:65535];
  logic [32:0]       position;
  logic              playing;
  logic [STEP_W-1:0] step_ratio;
  logic [VOL_W-1:0]  volume;
  logic              mute;
  logic [FCNT_W-1:0] frame_count;
  logic [CCNT_W-1:0] channel_count;

  out_item_t results_due [$];

  // one stored channel of a frame, sign extended
  function automatic longint lane(bit [31:0] word, bit ch);
    logic signed [15:0] s;
    s = ch ? word[31:16] : word[15:0];
    return s;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // blend of the two frames around the position, scaled by volume,
  // rounded half up; positions at or past the last frame read it alone
  function automatic longint blended_sample(logic [16:0] frames, bit ch);
    logic [16:0] last;
    logic [32:0] last_pos;
    logic [32:0] p;
    logic [16:0] idx;
    longint      fr;
    longint      a;
    longint      b;
    longint      acc;
    last     = frames - 17'd1;
    last_pos = {last, 16'd0};
    p        = (position >= last_pos) ? last_pos : position;
    idx      = p[32:16];
    fr       = p[15:0];
    a        = lane(sample_mem[idx[15:0]], ch);
    if (idx < last) begin
      b   = lane(sample_mem[idx[15:0] + 16'd1], ch);
      acc = a * (65536 - fr) + b * fr;
    end else begin
      acc = a * 65536;
    end
    return (acc * longint'(volume) + ROUND_HALF) >>> 31;
  endfunction

  // apply one request to the player state, return the result it owes
  function automatic out_item_t play_item(in_item_t it);
    out_item_t   r;
    logic [16:0] frames;
    logic [32:0] span;
    logic [16:0] target;
    bit          buffered;
    r        = '0;
    frames   = (frame_count > FRAMES_MAX) ? FRAMES_MAX : frame_count;
    buffered = (frames != 17'd0) && (channel_count != '0);
    case (it.req_type)
      REQ_RENDER: begin
        r.out_left  = it.mix_left;
        r.out_right = it.mix_right;
        if (playing && !mute && buffered) begin
          r.out_left  = clip16(longint'(it.mix_left) + blended_sample(frames, 1'b0));
          r.out_right = clip16(longint'(it.mix_right) +
                               blended_sample(frames, channel_count >= 2'd2));
          n_voiced++;
          span = {frames, 16'd0};
          if (position >= span || span - position <= {13'd0, step_ratio}) begin
            playing    = 1'b0;
            position   = '0;
            r.finished = 1'b1;
            n_finished++;
          end else begin
            position = position + {13'd0, step_ratio};
          end
        end
      end
      REQ_LOAD: begin
        sample_mem[it.load_index] = {it.load_right, it.load_left};
        position = '0;
      end
      REQ_PLAY: begin
        if (buffered) playing = 1'b1;
        else r.status = 1'b1;
      end
      REQ_PAUSE: playing = 1'b0;
      REQ_STOP: begin
        playing  = 1'b0;
        position = '0;
      end
      REQ_SEEK: begin
        if (frames != 17'd0) begin
          target   = ({1'b0, it.seek_index} > frames - 17'd1) ? frames - 17'd1
                                                              : {1'b0, it.seek_index};
          position = {target, 16'd0};
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    r.is_playing     = playing;
    r.position_frame = position[32:16];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [32:0] want,
                             logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // beat watcher: register writes, then requests, then results
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      position      = '0;
      playing       = 1'b0;
      step_ratio    = STEP_RESET;
      volume        = VOLUME_UNITY;
      mute          = 1'b0;
      frame_count   = '0;
      channel_count = CCNT_RESET;
      results_due.delete();
      errors        = 0;
      n_voiced      = 0;
      n_finished    = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP_RATIO:    step_ratio    = cfg_data[STEP_W-1:0];
          REG_VOLUME:        volume        = cfg_data[VOL_W-1:0];
          REG_MUTE:          mute          = cfg_data[0];
          REG_FRAME_COUNT:   frame_count   = cfg_data[FCNT_W-1:0];
          REG_CHANNEL_COUNT: channel_count = cfg_data[CCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) results_due.push_back(play_item(in_data));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with nothing owed");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("out_left", want.out_left, out_data.out_left);
          check_field("out_right", want.out_right, out_data.out_right);
          check_field("is_playing", want.is_playing, out_data.is_playing);
          check_field("position_frame", want.position_frame, out_data.position_frame);
          check_field("finished", want.finished, out_data.finished);
          check_field("status", want.status, out_data.status);
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the sample player with a short directed opening (no buffer, refused
// requests, clamped seek, rounding, saturation, end of buffer) and then nine
// random phases under different register settings and idling patterns,
// including a full-size buffer. The checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import isp_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int         PHASE_ITEMS    = 95;
  localparam int         BIG_PHASE      = 2;
  localparam int         STALL_LIMIT    = 4000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int n_voiced;
  int n_finished;
  int n_sent;
  int n_req [8];
  int send_idle;
  int recv_idle;
  int stall_cycles;

  interpolating_sample_player_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  isp_player_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .n_voiced   (n_voiced),
    .n_finished (n_finished)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // request with random payload
  function automatic in_item_t item(logic [2:0] kind);
    logic [127:0] noise;
    in_item_t     it;
    noise       = {$urandom, $urandom, $urandom, $urandom};
    it          = noise[$bits(in_item_t)-1:0];
    it.req_type = kind;
    return it;
  endfunction

  // one request beat, with random gaps ahead of it
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    n_req[it.req_type]++;
  endtask

  task automatic send_kind(input logic [2:0] kind);
    send(item(kind));
  endtask

  task automatic send_render(input logic [15:0] left, input logic [15:0] right);
    in_item_t it;
    it           = item(REQ_RENDER);
    it.mix_left  = left;
    it.mix_right = right;
    send(it);
  endtask

  task automatic send_load(input logic [15:0] idx, input logic [15:0] left,
                           input logic [15:0] right);
    in_item_t it;
    it            = item(REQ_LOAD);
    it.load_index = idx;
    it.load_left  = left;
    it.load_right = right;
    send(it);
  endtask

  task automatic send_seek(input logic [15:0] idx);
    in_item_t it;
    it            = item(REQ_SEEK);
    it.seek_index = idx;
    send(it);
  endtask

  // stop sending, wait for every owed result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [STEP_W-1:0] step, input logic [VOL_W-1:0] vol,
                          input logic mute_on, input logic [FCNT_W-1:0] frames,
                          input logic [CCNT_W-1:0] chans);
    write_reg(REG_STEP_RATIO, CFG_DATA_W'(step));
    write_reg(REG_VOLUME, CFG_DATA_W'(vol));
    write_reg(REG_MUTE, CFG_DATA_W'(mute_on));
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(frames));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(chans));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int phase_end;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    send_idle  = 26;
    recv_idle  = 85;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no buffer: pass-through render, refused play and seek, unknown codes
    send_render(16'sh7fff, 16'sh8000);
    send_kind(REQ_PLAY);
    send_kind(REQ_SEEK);
    send_kind(REQ_UNKNOWN_LO);
    send(~item(REQ_UNKNOWN_HI) | item(REQ_UNKNOWN_HI));

    // four stereo frames, step 1.5, frame 2 gives half-way rounding both signs
    drain();
    set_regs(20'h18000, VOLUME_UNITY, 1'b0, 17'd4, 2'd2);
    send_load(16'd0, 16'sh7fff, 16'sh8000);
    send_load(16'd1, 16'sh8000, 16'sh7fff);
    send_load(16'd2, 16'sd101, -16'sd101);
    send_load(16'd3, 16'sh4000, 16'shc000);
    send_seek(16'hffff);
    send_seek(16'd1);
    send_render(16'sd5, -16'sd5);
    send_kind(REQ_PLAY);
    send_render(16'sh7fff, 16'sh8000);
    send_render(16'sh7fff, 16'sh8000);
    send_render(16'sd1, 16'sd1);
    send_kind(REQ_PLAY);
    send_kind(REQ_PAUSE);
    send_render(-16'sd1, 16'sd0);
    send_kind(REQ_PLAY);
    send_kind(REQ_STOP);
    send_load(16'hffff, 16'hffff, 16'hffff);

    // frames read by the random phases, but for the top of the full-size buffer, are written up front
    for (int f = 0; f < 64; f++) send_load(16'(f), 16'($urandom), 16'($urandom));

    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin send_idle = 26; recv_idle = 85; end
        1: begin send_idle = 85; recv_idle = 26; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      drain();
      case (phase)
        0: set_regs(20'($urandom_range(20'h30000, 20'h4000)),
                    16'($urandom_range(VOLUME_UNITY)), 1'b0,
                    17'($urandom_range(64, 1)), 2'd1);
        1: set_regs(20'hfffff, 16'hffff, 1'b0, 17'd64, 2'd2);
        BIG_PHASE: set_regs(20'($urandom_range(20'hfffff, 1)), VOLUME_UNITY, 1'b0,
                            $urandom_range(1) ? 17'd65536 : 17'h1ffff, 2'd3);
        3: set_regs(20'd1, 16'($urandom), 1'b0, 17'($urandom_range(3, 1)), 2'd2);
        4: set_regs(20'($urandom), 16'($urandom), 1'b0, 17'd0, 2'($urandom));
        5: set_regs(20'($urandom_range(20'h40000, 1)), 16'd0, 1'b1,
                    17'($urandom_range(64, 1)), 2'd2);
        6: set_regs(20'd0, 16'($urandom), 1'b0, 17'($urandom_range(64, 1)), 2'd3);
        7: set_regs(20'($urandom_range(20'h40000, 1)), 16'($urandom), 1'b0,
                    17'($urandom_range(64, 1)), 2'd0);
        default: set_regs(20'($urandom_range(20'hfffff, 1)), 16'($urandom), 1'b0,
                          17'($urandom_range(64, 1)), 2'($urandom_range(3, 1)));
      endcase
      phase_end = n_sent + PHASE_ITEMS;

      // top of a full-size buffer: only positions there may be played
      if (phase == BIG_PHASE) begin
        for (int f = 65520; f < 65536; f++)
          send_load(16'(f), 16'($urandom), 16'($urandom));
        send_kind(REQ_STOP);
      end

      while (n_sent < phase_end) begin
        if (phase == BIG_PHASE) begin
          if ($urandom_range(99) < 85) begin
            send_seek(16'($urandom_range(65535, 65520)));
            send_kind(REQ_PLAY);
            repeat ($urandom_range(12, 2)) begin
              if ($urandom_range(9) == 0) send_kind(REQ_PAUSE);
              else send_render(16'($urandom), 16'($urandom));
            end
          end else begin
            case ($urandom_range(3))
              0: send_kind(REQ_RENDER);
              1: send_kind(REQ_PAUSE);
              2: send_seek(16'($urandom_range(65535, 65520)));
              default: send_kind($urandom_range(1) ? REQ_UNKNOWN_LO : REQ_UNKNOWN_HI);
            endcase
          end
        end else begin
          // mostly seek, play and a run of renders; the rest is any request
          if ($urandom_range(99) < 70) begin
            if ($urandom_range(1)) send_seek($urandom_range(1) ? 16'($urandom_range(63))
                                                               : 16'($urandom));
            send_kind(REQ_PLAY);
            repeat ($urandom_range(12, 2)) send_render(16'($urandom), 16'($urandom));
          end else begin
            send_kind(3'($urandom_range(7)));
          end
        end
      end
    end

    drain();
    $display("covered: %0d request beats: %0d render, %0d load, %0d seek, %0d play,",
             n_sent, n_req[REQ_RENDER], n_req[REQ_LOAD], n_req[REQ_SEEK], n_req[REQ_PLAY]);
    $display("covered: %0d pause, %0d stop, %0d unknown; %0d voiced, %0d hit the end",
             n_req[REQ_PAUSE], n_req[REQ_STOP],
             n_req[REQ_UNKNOWN_LO] + n_req[REQ_UNKNOWN_HI], n_voiced, n_finished);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
